// File: rtl/core/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and codes for the delta-stepping shortest path block.
// ----------------------------------------------------------------------------
package dss_pkg;

   // store sizes
   localparam int MAX_VERTICES = 1024;
   localparam int MAX_EDGES    = 8192;

   // request actions
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_SOLVE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;
   localparam logic [1:0] ST_UNSOLVED = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_DELTA  = 2'd0;
   localparam logic [1:0] CSR_SOURCE = 2'd1;

   localparam logic [15:0] DELTA_RESET  = 16'd256;
   localparam logic [9:0]  SOURCE_RESET = 10'd1;

   localparam logic [31:0] UNREACHED = 32'hFFFF_FFFF;
   localparam logic [32:0] SUM_CAP   = 33'h0_FFFF_FFFE;

   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  edge_from;
      logic [9:0]  edge_to;
      logic [15:0] edge_weight;
      logic [9:0]  read_vertex;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] distance;
      logic        reachable;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_SOLVE,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type  op;
      req_type item;
   } cmd_type;

   typedef enum logic [4:0] {
      BK_IDLE,
      BK_RD_WAIT,
      BK_INIT,
      BK_SRC,
      BK_SCAN_RD,
      BK_SCAN_USE,
      BK_DIV_GO,
      BK_DIV_WAIT,
      BK_EC_RD,
      BK_EC_TD,
      BK_EC_USE,
      BK_ST_RD,
      BK_ST_USE,
      BK_AP_RD,
      BK_AP_TD,
      BK_AP_USE,
      BK_DONE
   } bk_state_type;

endpackage

// File: rtl/core/delta_stepping_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_stepping_shortest_path
// Edge list store with a delta-stepping shortest path solver and reads.
// ----------------------------------------------------------------------------
//  channel   ports                        moves
//  request   push, full, req_item         load, solve, read or clear
//  result    empty, pop, rsp_item         status, distance, reachable
//  config    csr_we, csr_index, csr_wdata delta, source vertex
//
//  The execution side takes one request at a time. A solve first clears the
//  distances of vertices up to the highest one, then per bucket scans the
//  vertices, divides by delta, walks the edges, settles vertices in each
//  light pass and applies each relaxation.
//  Reset is synchronous. Two-entry queues let requests and results stall apart.
// ----------------------------------------------------------------------------
module delta_stepping_shortest_path (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  dss_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output dss_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import dss_pkg::*;

   logic [15:0] delta_ff;
   logic [9:0]  source_ff;
   logic        cmd_valid, cmd_take;
   cmd_type     cmd;
   logic        out_full, out_push;
   rsp_type     out_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff  <= DELTA_RESET;
         source_ff <= SOURCE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DELTA:  delta_ff  <= csr_wdata;
            CSR_SOURCE: source_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   dss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   dss_back u_back (
      .clock         (clock),
      .reset         (reset),
      .delta         (delta_ff),
      .source_vertex (source_ff),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take),
      .out_full      (out_full),
      .out_push      (out_push),
      .out_data      (out_data)
   );

   dss_rsq u_rsq (
      .clock    (clock),
      .reset    (reset),
      .in_push  (out_push),
      .in_data  (out_data),
      .in_full  (out_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// File: rtl/core/dss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_front
// Accepts requests, decodes the action and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module dss_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  dss_pkg::req_type req_item,
   output logic             cmd_valid,
   output dss_pkg::cmd_type cmd,
   input  logic             cmd_take
);
   import dss_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    decoded;
   logic       do_push, do_pop;

   // classify the action
   always_comb begin
      decoded.item = req_item;
      case (req_item.action)
         ACT_LOAD:  decoded.op = OP_LOAD;
         ACT_SOLVE: decoded.op = OP_SOLVE;
         ACT_READ:  decoded.op = OP_READ;
         default:   decoded.op = OP_CLEAR;
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   // queue pointers
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: rtl/core/dss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_div
// Restoring divider, one quotient bit a cycle, giving the remainder.
// ----------------------------------------------------------------------------
module dss_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [15:0] den,
   output logic        done,
   output logic [15:0] rem
);
   logic [31:0] num_ff, num_in;
   logic [15:0] den_ff, den_in;
   logic [15:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   // one shift and subtract step
   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[31]};
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = 16'd0;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[30:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 16'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[15:0];
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// File: rtl/core/dss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_back
// Executes commands: edge store, distance table and the bucket sequencer.
// ----------------------------------------------------------------------------
module dss_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      delta,
   input  logic [9:0]       source_vertex,
   input  logic             cmd_valid,
   input  dss_pkg::cmd_type cmd,
   output logic             cmd_take,
   input  logic             out_full,
   output logic             out_push,
   output dss_pkg::rsp_type out_data
);
   import dss_pkg::*;

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int EW  = $clog2(MAX_EDGES);
   localparam int EAW = (EW > 0) ? EW : 1;
   localparam int CW  = $clog2(MAX_EDGES + 1);
   localparam int EDW = 2 * VW + 16;
   localparam int RQW = VW + 32;
   localparam int TDW = 34;

   bk_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [9:0]    hiv_ff, hiv_in;
   logic          solved_ff, solved_in;
   logic [9:0]    vcnt_ff, vcnt_in;
   logic [CW-1:0] ecnt_ff, ecnt_in;
   logic [CW-1:0] rcnt_ff, rcnt_in;
   logic          any_ff, any_in;
   logic          heavy_ff, heavy_in;
   logic          found_ff, found_in;
   logic [31:0]   min_ff, min_in;
   logic [31:0]   lo_ff, lo_in;
   logic [32:0]   hib_ff, hib_in;
   rsp_type       res_ff, res_in;

   // memories; a distance entry carries its bucket and settled flags
   logic [TDW-1:0] td_mem   [MAX_VERTICES];
   logic [EDW-1:0] edge_mem [MAX_EDGES];
   logic [RQW-1:0] req_mem  [MAX_EDGES];

   logic [TDW-1:0] td_q;
   logic [EDW-1:0] edge_q;
   logic [RQW-1:0] req_q;

   logic           td_re, td_we;
   logic [VW-1:0]  td_ra, td_wa;
   logic [TDW-1:0] td_wd;
   logic           edge_re, edge_we;
   logic [EAW-1:0] edge_ra, edge_wa;
   logic [EDW-1:0] edge_wd;
   logic           req_re, req_we;
   logic [EAW-1:0] req_ra, req_wa;
   logic [RQW-1:0] req_wd;

   logic          div_start, div_done;
   logic [15:0]   div_rem;
   logic [15:0]   dw;
   logic [31:0]   td_rd;
   logic          q_inb, q_stl;
   logic [VW-1:0] e_tail, e_head, r_head, v_idx;
   logic [15:0]   e_w;
   logic [31:0]   r_dist;
   logic [32:0]   sum;
   logic [31:0]   sum_sat;
   logic          in_range, take_edge, found_now;
   logic [31:0]   lo_calc;

   dss_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (min_ff),
      .den   (dw),
      .done  (div_done),
      .rem   (div_rem)
   );

   // field views
   assign dw      = (delta == 16'd0) ? 16'd1 : delta;
   assign td_rd   = td_q[31:0];
   assign q_stl   = td_q[32];
   assign q_inb   = td_q[33];
   assign e_w     = edge_q[15:0];
   assign e_head  = edge_q[VW+15:16];
   assign e_tail  = edge_q[2*VW+15:VW+16];
   assign r_dist  = req_q[31:0];
   assign r_head  = req_q[VW+31:32];
   assign v_idx   = VW'(vcnt_ff);
   assign sum     = {1'b0, td_rd} + 33'(e_w);
   assign sum_sat = (sum > SUM_CAP) ? SUM_CAP[31:0] : sum[31:0];
   assign in_range = (td_rd >= lo_ff) && ({1'b0, td_rd} < hib_ff);
   assign lo_calc  = min_ff - 32'(div_rem);

   // next state and datapath control
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      hiv_in    = hiv_ff;
      solved_in = solved_ff;
      vcnt_in   = vcnt_ff;
      ecnt_in   = ecnt_ff;
      rcnt_in   = rcnt_ff;
      any_in    = any_ff;
      heavy_in  = heavy_ff;
      found_in  = found_ff;
      min_in    = min_ff;
      lo_in     = lo_ff;
      hib_in    = hib_ff;
      res_in    = res_ff;
      cmd_take  = 1'b0;
      out_push  = 1'b0;
      td_re     = 1'b0;
      td_ra     = v_idx;
      td_we     = 1'b0;
      td_wa     = v_idx;
      td_wd     = '0;
      edge_re   = 1'b0;
      edge_ra   = ecnt_ff[EAW-1:0];
      edge_we   = 1'b0;
      edge_wa   = cnt_ff[EAW-1:0];
      edge_wd   = {VW'(cmd.item.edge_from), VW'(cmd.item.edge_to), cmd.item.edge_weight};
      req_re    = 1'b0;
      req_ra    = ecnt_ff[EAW-1:0];
      req_we    = 1'b0;
      req_wa    = rcnt_ff[EAW-1:0];
      req_wd    = {e_head, sum_sat};
      div_start = 1'b0;
      take_edge = 1'b0;
      found_now = found_ff;

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               res_in   = '{status: ST_OK, distance: 32'd0, reachable: 1'b0};
               state_in = BK_DONE;
               case (cmd.op)
                  OP_LOAD: begin
                     if (cnt_ff == CW'(MAX_EDGES)) begin
                        res_in.status = ST_FULL;
                     end else if ((32'(cmd.item.edge_from) >= MAX_VERTICES) ||
                                  (32'(cmd.item.edge_to) >= MAX_VERTICES)) begin
                        res_in.status = ST_RANGE;
                     end else begin
                        edge_we   = 1'b1;
                        cnt_in    = cnt_ff + CW'(1);
                        solved_in = 1'b0;
                        if (cmd.item.edge_from > hiv_in) hiv_in = cmd.item.edge_from;
                        if (cmd.item.edge_to > hiv_in) hiv_in = cmd.item.edge_to;
                     end
                  end
                  OP_SOLVE: begin
                     if (source_vertex > hiv_ff) begin
                        res_in.status = ST_RANGE;
                        solved_in     = 1'b0;
                     end else begin
                        vcnt_in  = 10'd0;
                        state_in = BK_INIT;
                     end
                  end
                  OP_READ: begin
                     if (!solved_ff) begin
                        res_in.status = ST_UNSOLVED;
                     end else if ((cmd.item.read_vertex > hiv_ff) ||
                                  (32'(cmd.item.read_vertex) >= MAX_VERTICES)) begin
                        res_in.status = ST_RANGE;
                     end else begin
                        td_re    = 1'b1;
                        td_ra    = VW'(cmd.item.read_vertex);
                        state_in = BK_RD_WAIT;
                     end
                  end
                  default: begin
                     cnt_in    = '0;
                     hiv_in    = 10'd0;
                     solved_in = 1'b0;
                  end
               endcase
            end
         end
         BK_RD_WAIT: begin
            if (td_rd != UNREACHED) begin
               res_in.distance  = td_rd;
               res_in.reachable = 1'b1;
            end
            state_in = BK_DONE;
         end
         // clear distances and flags of vertices up to the highest one
         BK_INIT: begin
            td_we = 1'b1;
            td_wd = {1'b0, 1'b0, UNREACHED};
            if (vcnt_ff == hiv_ff) begin
               state_in = BK_SRC;
            end else begin
               vcnt_in = vcnt_ff + 10'd1;
            end
         end
         // source at distance zero in the first bucket
         BK_SRC: begin
            td_we    = 1'b1;
            td_wa    = VW'(source_vertex);
            td_wd    = {1'b1, 1'b0, 32'd0};
            vcnt_in  = 10'd0;
            found_in = 1'b0;
            heavy_in = 1'b0;
            state_in = BK_SCAN_RD;
         end
         // find the smallest distance still in a bucket, drop settled marks
         BK_SCAN_RD: begin
            td_re    = 1'b1;
            state_in = BK_SCAN_USE;
         end
         BK_SCAN_USE: begin
            if (q_stl) begin
               td_we = 1'b1;
               td_wd = {q_inb, 1'b0, td_rd};
            end
            if (q_inb && (!found_ff || td_rd < min_ff)) begin
               min_in    = td_rd;
               found_now = 1'b1;
            end
            found_in = found_now;
            if (vcnt_ff == hiv_ff) begin
               if (found_now) begin
                  state_in = BK_DIV_GO;
               end else begin
                  solved_in = 1'b1;
                  state_in  = BK_DONE;
               end
            end else begin
               vcnt_in  = vcnt_ff + 10'd1;
               state_in = BK_SCAN_RD;
            end
         end
         BK_DIV_GO: begin
            div_start = 1'b1;
            state_in  = BK_DIV_WAIT;
         end
         BK_DIV_WAIT: begin
            if (div_done) begin
               lo_in    = lo_calc;
               hib_in   = {1'b0, lo_calc} + 33'(dw);
               ecnt_in  = '0;
               rcnt_in  = '0;
               heavy_in = 1'b0;
               state_in = BK_EC_RD;
            end
         end
         // walk the edges and collect relaxation requests
         BK_EC_RD: begin
            if (ecnt_ff == cnt_ff) begin
               ecnt_in = '0;
               if (heavy_ff) begin
                  state_in = BK_AP_RD;
               end else begin
                  vcnt_in  = 10'd0;
                  any_in   = 1'b0;
                  state_in = BK_ST_RD;
               end
            end else begin
               edge_re  = 1'b1;
               state_in = BK_EC_TD;
            end
         end
         BK_EC_TD: begin
            td_re    = 1'b1;
            td_ra    = e_tail;
            state_in = BK_EC_USE;
         end
         BK_EC_USE: begin
            if (heavy_ff) begin
               take_edge = q_stl && (e_w > dw);
            end else begin
               take_edge = q_inb && in_range && (e_w <= dw);
            end
            if (take_edge) begin
               req_we  = 1'b1;
               rcnt_in = rcnt_ff + CW'(1);
            end
            ecnt_in  = ecnt_ff + CW'(1);
            state_in = BK_EC_RD;
         end
         // settle the vertices of the current bucket
         BK_ST_RD: begin
            td_re    = 1'b1;
            state_in = BK_ST_USE;
         end
         BK_ST_USE: begin
            if (q_inb && in_range) begin
               td_we  = 1'b1;
               td_wd  = {1'b0, 1'b1, td_rd};
               any_in = 1'b1;
            end
            if (vcnt_ff == hiv_ff) begin
               ecnt_in = '0;
               if (any_in) begin
                  state_in = BK_AP_RD;
               end else begin
                  heavy_in = 1'b1;
                  rcnt_in  = '0;
                  state_in = BK_EC_RD;
               end
            end else begin
               vcnt_in  = vcnt_ff + 10'd1;
               state_in = BK_ST_RD;
            end
         end
         // apply the collected requests one at a time
         BK_AP_RD: begin
            if (ecnt_ff == rcnt_ff) begin
               ecnt_in = '0;
               rcnt_in = '0;
               if (heavy_ff) begin
                  heavy_in = 1'b0;
                  vcnt_in  = 10'd0;
                  found_in = 1'b0;
                  state_in = BK_SCAN_RD;
               end else begin
                  state_in = BK_EC_RD;
               end
            end else begin
               req_re   = 1'b1;
               state_in = BK_AP_TD;
            end
         end
         BK_AP_TD: begin
            td_re    = 1'b1;
            td_ra    = r_head;
            state_in = BK_AP_USE;
         end
         BK_AP_USE: begin
            if (r_dist < td_rd) begin
               td_we = 1'b1;
               td_wa = r_head;
               td_wd = {1'b1, q_stl, r_dist};
            end
            ecnt_in  = ecnt_ff + CW'(1);
            state_in = BK_AP_RD;
         end
         BK_DONE: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign out_data = res_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         cnt_ff    <= '0;
         hiv_ff    <= 10'd0;
         solved_ff <= 1'b0;
         heavy_ff  <= 1'b0;
         vcnt_ff   <= 10'd0;
         ecnt_ff   <= '0;
         rcnt_ff   <= '0;
         any_ff    <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         hiv_ff    <= hiv_in;
         solved_ff <= solved_in;
         heavy_ff  <= heavy_in;
         vcnt_ff   <= vcnt_in;
         ecnt_ff   <= ecnt_in;
         rcnt_ff   <= rcnt_in;
         any_ff    <= any_in;
         found_ff  <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      min_ff <= min_in;
      lo_ff  <= lo_in;
      hib_ff <= hib_in;
      res_ff <= res_in;
   end

   // distance memory
   always_ff @(posedge clock) begin
      if (td_we) begin
         td_mem[td_wa] <= td_wd;
      end
      if (td_re) begin
         td_q <= td_mem[td_ra];
      end
   end

   // edge memory
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      if (edge_re) begin
         edge_q <= edge_mem[edge_ra];
      end
   end

   // request memory
   always_ff @(posedge clock) begin
      if (req_we) begin
         req_mem[req_wa] <= req_wd;
      end
      if (req_re) begin
         req_q <= req_mem[req_ra];
      end
   end

endmodule

// File: rtl/core/dss_rsq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_rsq
// Two-entry result queue between the execution side and the result port.
// ----------------------------------------------------------------------------
module dss_rsq (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_push,
   input  dss_pkg::rsp_type in_data,
   output logic             in_full,
   output logic             empty,
   input  logic             pop,
   output dss_pkg::rsp_type rsp_item
);
   import dss_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign in_full  = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_item = slot_ff[rd_ptr_ff];
   assign do_push  = in_push && !in_full;
   assign do_pop   = pop && !empty;

   // queue pointers
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
